// ----- hdl/gmac_pkg.sv -----
// Package for the GAXPY multiply-accumulate core: request and result types,
// command codes, register map and sizing constants.
// No dependencies; every other file of the core imports it.
`timescale 1ns / 1ps

package gmac_pkg;

    localparam int MAX_COLS    = 64;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int CNT_W       = $clog2(MAX_COLS + 1);
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int ROW_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int OF_DEPTH    = 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [CNT_W-1:0] N_COLS_RESET = CNT_W'(MAX_COLS);

    // Register index of n_cols (paddr bit 2 selects the register).
    localparam logic REG_N_COLS = 1'b0;

    localparam logic signed [DATA_W-1:0] Y_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Y_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD_X    = 2'd0,
        CMD_START_ROW = 2'd1,
        CMD_ELEMENT   = 2'd2,
        CMD_UNUSED    = 2'd3
    } command_t;

    typedef struct packed {
        command_t                  command;
        logic [5:0]                x_index;
        logic signed [DATA_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  y_value;
        logic [ROW_W-1:0]          row_index;
        logic                      saturated;
    } out_item_t;

    // Work passed from the front end to the arithmetic back end.
    typedef struct packed {
        logic                      is_start;
        logic                      last;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  x_value;
    } work_t;

endpackage

// ----- hdl/gmac_front.sv -----
// Front end of the GAXPY core: accepts requests, keeps the x store and the
// column count, and hands start-row and element work to the work queue.
// Depends on gmac_pkg.
`timescale 1ns / 1ps

module gmac_front
    import gmac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  in_item_t         item,
    input  logic [CNT_W-1:0] eff_cols,
    output logic             q_wr,
    output work_t            q_data,
    input  logic             q_full
);

    logic [DATA_W-1:0]        x_mem [MAX_COLS];
    logic signed [DATA_W-1:0] x_rd_reg;

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic                     s1_is_start_reg;
    logic                     s1_last_reg;
    logic signed [DATA_W-1:0] s1_value_reg;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [CNT_W-1:0]         count_inc;
    logic                     elem_last;

    logic                     accept;
    logic                     is_load;
    logic                     is_start;
    logic                     is_elem;

    assign full    = s1_valid_reg & q_full;
    assign accept  = push & ~full;
    assign is_load  = accept && (item.command == CMD_LOAD_X);
    assign is_start = accept && (item.command == CMD_START_ROW);
    assign is_elem  = accept && (item.command == CMD_ELEMENT);

    assign q_wr = s1_valid_reg & ~q_full;

    assign count_inc = count_reg + 1'b1;
    // A row closes once the count reaches the effective width, also when the
    // width was lowered below the count in the middle of a row.
    assign elem_last = (count_inc >= eff_cols);

    always_comb
    begin
        count_next = count_reg;
        if (is_start)
        begin
            count_next = '0;
        end
        else if (is_elem)
        begin
            count_next = elem_last ? '0 : count_inc;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (is_start || is_elem)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_wr)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_start || is_elem)
        begin
            s1_is_start_reg <= is_start;
            s1_last_reg     <= is_elem & elem_last;
            s1_value_reg    <= item.value;
        end
    end

    // The count is below MAX_COLS before it is incremented, so its low bits
    // address the store directly.
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            x_mem[item.x_index] <= item.value;
        end
        if (is_elem)
        begin
            x_rd_reg <= x_mem[count_reg[COL_W-1:0]];
        end
    end

    always_comb
    begin
        q_data.is_start = s1_is_start_reg;
        q_data.last     = s1_last_reg;
        q_data.value    = s1_value_reg;
        q_data.x_value  = x_rd_reg;
    end

endmodule

// ----- hdl/gmac_queue.sv -----
// Short work queue between the front end and the back end of the core.
// Depends on gmac_pkg.
`timescale 1ns / 1ps

module gmac_queue
    import gmac_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  work_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output work_t rd_data,
    output logic  empty
);

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/gmac_back.sv -----
// Back end of the GAXPY core: multiply stage, 64-bit accumulator, output
// saturation, row counter and the result queue.
// Depends on gmac_pkg.
`timescale 1ns / 1ps

module gmac_back
    import gmac_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    output logic      q_rd,
    input  work_t     q_data,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    localparam int OPTR_W = $clog2(OF_DEPTH);
    localparam int OCNT_W = $clog2(OF_DEPTH + 1);

    logic                     en;

    logic                     m_valid_reg;
    logic                     m_is_start_reg;
    logic                     m_last_reg;
    logic signed [DATA_W-1:0] m_value_reg;
    logic signed [ACC_W-1:0]  prod_reg;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         acc_sum;
    logic [ACC_W-1:0]         acc_load;

    logic                     fin_valid_reg;
    logic                     fin_valid_next;
    logic [ACC_W-1:0]         fin_reg;
    logic [ACC_W-1:0]         fin_next;
    logic                     fin_fits;
    out_item_t                fin_item;

    logic [ROW_W-1:0]         row_count_reg;

    out_item_t                of_mem [OF_DEPTH];
    logic [OPTR_W-1:0]        of_wr_ptr_reg;
    logic [OPTR_W-1:0]        of_rd_ptr_reg;
    logic [OCNT_W-1:0]        of_count_reg;
    logic                     of_full;
    logic                     of_push;
    logic                     of_pop;

    // The whole back end holds while a finished row waits on a full queue.
    assign en      = ~(fin_valid_reg & of_full);
    assign q_rd    = en & ~q_empty;
    assign of_push = en & fin_valid_reg;
    assign of_pop  = pop & ~empty;

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            m_is_start_reg <= q_data.is_start;
            m_last_reg     <= q_data.last;
            m_value_reg    <= q_data.value;
            prod_reg       <= q_data.value * q_data.x_value;
        end
    end

    // The arithmetic shift floors the product back to FRAC_BITS fraction bits.
    assign acc_sum  = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
    assign acc_load = {{(ACC_W - DATA_W){m_value_reg[DATA_W-1]}}, m_value_reg};

    always_comb
    begin
        acc_next       = acc_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg;
        if (en)
        begin
            fin_valid_next = 1'b0;
            if (m_valid_reg)
            begin
                if (m_is_start_reg)
                begin
                    acc_next = acc_load;
                end
                else if (m_last_reg)
                begin
                    acc_next       = '0;
                    fin_next       = acc_sum;
                    fin_valid_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_sum;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
            row_count_reg <= '0;
        end
        else
        begin
            if (en)
            begin
                m_valid_reg <= q_rd;
            end
            acc_reg       <= acc_next;
            fin_valid_reg <= fin_valid_next;
            if (of_push)
            begin
                row_count_reg <= row_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg <= fin_next;
    end

    // The value fits in 32 bits when its top 33 bits are all equal.
    assign fin_fits = (&fin_reg[ACC_W-1:DATA_W-1]) | ~(|fin_reg[ACC_W-1:DATA_W-1]);

    always_comb
    begin
        fin_item.row_index = row_count_reg;
        fin_item.saturated = ~fin_fits;
        if (fin_fits)
        begin
            fin_item.y_value = fin_reg[DATA_W-1:0];
        end
        else
        begin
            fin_item.y_value = fin_reg[ACC_W-1] ? Y_MIN : Y_MAX;
        end
    end

    assign of_full = (of_count_reg == OCNT_W'(OF_DEPTH));
    assign empty   = (of_count_reg == '0);
    assign result  = of_mem[of_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_wr_ptr_reg <= '0;
            of_rd_ptr_reg <= '0;
            of_count_reg  <= '0;
        end
        else
        begin
            if (of_push)
            begin
                of_wr_ptr_reg <= (of_wr_ptr_reg == OPTR_W'(OF_DEPTH - 1)) ?
                                 '0 : of_wr_ptr_reg + 1'b1;
            end
            if (of_pop)
            begin
                of_rd_ptr_reg <= (of_rd_ptr_reg == OPTR_W'(OF_DEPTH - 1)) ?
                                 '0 : of_rd_ptr_reg + 1'b1;
            end
            if (of_push && !of_pop)
            begin
                of_count_reg <= of_count_reg + 1'b1;
            end
            else if (of_pop && !of_push)
            begin
                of_count_reg <= of_count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (of_push)
        begin
            of_mem[of_wr_ptr_reg] <= fin_item;
        end
    end

endmodule

// ----- hdl/gaxpy_matrix_vector_mac_core.sv -----
// Top level of the GAXPY row engine: configuration register and the
// front end, work queue and back end. Depends on gmac_pkg, gmac_front,
// gmac_queue and gmac_back.
`timescale 1ns / 1ps

// The core computes y = y + A*x one row at a time in Q16.16 fixed point.
// Requests enter through a queue-style port (push/full): a load request
// writes x[x_index], a start-row request sets the accumulator to the row's
// starting y, and an element request multiplies A(i,j) by x[j] for the next
// column and adds the product, floored to 16 fraction bits, into a 64-bit
// accumulator. After n_cols elements the row's y, clipped to 32 bits with a
// saturation flag, and its 16-bit row number appear on the result port
// (empty/pop). Every x entry must be loaded before an element reads it.
// The core takes one request in every clock cycle while full is low, with
// no gaps between rows; the single 32x32 multiplier and the 64-bit
// accumulator each complete one element per cycle unless the back end holds
// for a full result queue. The x store is read at the edge that accepts a
// row's last element; the row then passes through the work queue, the
// multiply, the accumulate and into the result queue. The front end
// and back end are separated by a four-entry work queue, so a stalled
// result consumer fills that queue before full is raised. n_cols is
// written through the APB port at byte address 0 and may only be changed
// while no row result is pending; a value of 0 acts as 1 and values above
// 64 act as 64.

module gaxpy_matrix_vector_mac_core
    import gmac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  in_item_t           item,
    input  logic               pop,
    output logic               empty,
    output out_item_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CNT_W-1:0] n_cols_reg;
    logic [CNT_W-1:0] eff_cols;
    logic             reg_hit;

    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    work_t            q_wr_data;
    work_t            q_rd_data;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_N_COLS);
    assign prdata  = reg_hit ? PDATA_W'(n_cols_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_cols_reg <= N_COLS_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            n_cols_reg <= pwdata[CNT_W-1:0];
        end
    end

    // Row width as the engine uses it: clamped to the range 1 to MAX_COLS.
    always_comb
    begin
        if (n_cols_reg == '0)
        begin
            eff_cols = CNT_W'(1);
        end
        else if (n_cols_reg > CNT_W'(MAX_COLS))
        begin
            eff_cols = CNT_W'(MAX_COLS);
        end
        else
        begin
            eff_cols = n_cols_reg;
        end
    end

    gmac_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .eff_cols (eff_cols),
        .q_wr     (q_wr),
        .q_data   (q_wr_data),
        .q_full   (q_full)
    );

    gmac_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    gmac_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .q_data  (q_rd_data),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ----- hdl/gmac_checker.sv -----
// Port-level checker for the GAXPY core, bound to the top level.
// Depends on gmac_pkg and gaxpy_matrix_vector_mac_core.
`timescale 1ns / 1ps

module gmac_port_props
    import gmac_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pop,
    input logic               empty,
    input out_item_t          result,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // Nothing can be waiting straight after reset is released.
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result port not empty after reset");

    // A waiting result stays put until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    // Consecutive rows carry consecutive row numbers.
    a_row_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty) |=>
            (empty || result.row_index == ROW_W'($past(result.row_index) + 1'b1)))
        else $error("row number did not advance by one");

    // A saturated result sits exactly on one of the two bounds.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.saturated) |-> (result.y_value == Y_MAX || result.y_value == Y_MIN))
        else $error("saturated result not at a bound");

    // A write to n_cols reads back its low bits on the next cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_N_COLS) |=>
            (paddr[PADDR_W-1:2] != REG_N_COLS ||
             prdata == PDATA_W'($past(pwdata[CNT_W-1:0]))))
        else $error("n_cols read-back mismatch");

endmodule

bind gaxpy_matrix_vector_mac_core gmac_port_props u_gmac_port_props (
    .clk     (clk),
    .rst_n   (rst_n),
    .pop     (pop),
    .empty   (empty),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);
